// File: src/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the Bresenham line stepper
// Coordinate widths, register map, reset values, sequencer states and the
// payload words of the line request and pixel result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  localparam int unsigned CoordW   = 8;   // line coordinates
  localparam int unsigned ScreenW  = 9;   // screen coordinates after offset
  localparam int unsigned NumSlots = 4;   // pixels per result word
  localparam int unsigned SlotW    = 2;   // index into the slots
  localparam int unsigned AddrW    = 4;   // APB byte address
  localparam int unsigned DataW    = 32;  // APB data

  localparam logic [CoordW-1:0]  PanRst        = 8'd16;
  localparam logic [ScreenW-1:0] ClipWidthRst  = 9'd320;
  localparam logic [ScreenW-1:0] ClipHeightRst = 9'd160;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegPan        = 2'd0,
    RegClipWidth  = 2'd1,
    RegClipHeight = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StStep
  } state_e;

  typedef struct packed {
    logic              load_start;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } line_req_t;

  typedef struct packed {
    logic [ScreenW-1:0]  pixel_x0;
    logic [ScreenW-1:0]  pixel_y0;
    logic [ScreenW-1:0]  pixel_x1;
    logic [ScreenW-1:0]  pixel_y1;
    logic [ScreenW-1:0]  pixel_x2;
    logic [ScreenW-1:0]  pixel_y2;
    logic [ScreenW-1:0]  pixel_x3;
    logic [ScreenW-1:0]  pixel_y3;
    logic [NumSlots-1:0] pixel_mask;
    logic                last;
  } pix_word_t;

endpackage

`default_nettype wire

// File: src/bls_in_if.sv
// ----------------------------------------------------------------------------
// bls_in_if: line request channel
// Valid/ready channel carrying one line request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bls_in_if
  import bls_pkg::*;
();

  logic      valid;
  logic      ready;
  line_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: src/bls_out_if.sv
// ----------------------------------------------------------------------------
// bls_out_if: pixel result channel
// Valid/ready channel carrying one word of up to four screen pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bls_out_if
  import bls_pkg::*;
();

  logic      valid;
  logic      ready;
  pix_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: src/bresenham_line_stepper_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top: Bresenham line rasterizer
// Steps one pixel per cycle unless stalled, from the loaded or kept point toward
// the end, offsets each pixel onto the screen, clips it, packs four to a word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+--------------------------------------
//  in_i     | in  | valid/ready        | load_start, start_x/y, end_x/y
//  out_o    | out | valid/ready        | pixel_x0..3, pixel_y0..3, mask, last
//  apb      | in  | psel/penable/pwrite| pan, clip_width, clip_height
//
//  Steps: accept, setup, then one Bresenham step per pixel in a single
//  err/coordinate update unit; a zero-length line returns to idle after setup.
//  Reset clears the sequencer, the current point, the output valid and the
//  registers to their defaults (offset 16, clip 320 x 160).
//  Stalls: stepping holds on a word-closing pixel while the output register
//  is full and not being taken. in_i is ready only between lines; a finished
//  word may still wait in the output register while the next line is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_stepper_top
  import bls_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  bls_in_if.sink                in_i,
  bls_out_if.source             out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CoordW-1:0]  pan_q;
  logic [ScreenW-1:0] clip_width_q;
  logic [ScreenW-1:0] clip_height_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q         <= PanRst;
      clip_width_q  <= ClipWidthRst;
      clip_height_q <= ClipHeightRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegPan:        pan_q         <= pwdata[CoordW-1:0];
        RegClipWidth:  clip_width_q  <= pwdata[ScreenW-1:0];
        RegClipHeight: clip_height_q <= pwdata[ScreenW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegPan:        prdata = {{(DataW-CoordW){1'b0}}, pan_q};
      RegClipWidth:  prdata = {{(DataW-ScreenW){1'b0}}, clip_width_q};
      RegClipHeight: prdata = {{(DataW-ScreenW){1'b0}}, clip_height_q};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer and line state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CoordW-1:0] cur_x_q, cur_y_q;      // kept current point
  logic [CoordW-1:0] end_x_q, end_y_q;
  logic [CoordW-1:0] major_q, minor_q, err_q, rem_q;
  logic              xneg_q, yneg_q, xmajor_q;
  logic [SlotW-1:0]  slot_q;

  // staging for the word being filled
  logic [ScreenW-1:0] stg_x_q [NumSlots];
  logic [ScreenW-1:0] stg_y_q [NumSlots];
  logic [NumSlots-1:0] stg_m_q;

  logic      out_valid_q;
  pix_word_t out_data_q;

  logic in_acc;
  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;

  // setup: spans and directions
  logic              s_xneg, s_yneg, s_xmajor, s_zero;
  logic [CoordW-1:0] s_adx, s_ady;

  always_comb begin
    s_xneg   = end_x_q < cur_x_q;
    s_yneg   = end_y_q < cur_y_q;
    s_adx    = s_xneg ? (cur_x_q - end_x_q) : (end_x_q - cur_x_q);
    s_ady    = s_yneg ? (cur_y_q - end_y_q) : (end_y_q - cur_y_q);
    s_xmajor = s_adx >= s_ady;
    s_zero   = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
  end

  // step unit: one Bresenham update per cycle unless the output stalls
  logic [CoordW-1:0]  err_sum, err_nxt, x_nxt, y_nxt;
  logic               minor_step;
  logic [ScreenW-1:0] scr_x, scr_y;
  logic               in_clip, close, out_free, advance, last_pix;

  always_comb begin
    err_sum    = err_q + minor_q;  // 8-bit, wraps
    minor_step = err_sum >= major_q;
    err_nxt    = minor_step ? (err_sum - major_q) : err_sum;
    x_nxt      = cur_x_q;
    y_nxt      = cur_y_q;
    if (xmajor_q || minor_step) begin
      x_nxt = xneg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
    end
    if (!xmajor_q || minor_step) begin
      y_nxt = yneg_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
    end
    scr_x    = {1'b0, x_nxt} + {1'b0, pan_q};
    scr_y    = {1'b0, y_nxt} + {1'b0, pan_q};
    in_clip  = (scr_x < clip_width_q) && (scr_y < clip_height_q);
    last_pix = (rem_q == CoordW'(1));
    close    = (slot_q == SlotW'(NumSlots - 1)) || last_pix;
    out_free = !out_valid_q || out_o.ready;
    advance  = (state_q == StStep) && (!close || out_free);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc) state_d = StSetup;
      StSetup: state_d = s_zero ? StIdle : StStep;
      StStep:  if (advance && last_pix) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // word assembled from staging plus the pixel of this step
  logic [ScreenW-1:0]  wx [NumSlots];
  logic [ScreenW-1:0]  wy [NumSlots];
  logic [NumSlots-1:0] wm;
  pix_word_t           word_d;

  always_comb begin
    for (int s = 0; s < NumSlots; s++) begin
      if (SlotW'(s) == slot_q) begin
        wx[s] = scr_x;
        wy[s] = scr_y;
        wm[s] = in_clip;
      end else begin
        wx[s] = stg_x_q[s];
        wy[s] = stg_y_q[s];
        wm[s] = stg_m_q[s];
      end
    end
    word_d.pixel_x0   = wx[0];
    word_d.pixel_y0   = wy[0];
    word_d.pixel_x1   = wx[1];
    word_d.pixel_y1   = wy[1];
    word_d.pixel_x2   = wx[2];
    word_d.pixel_y2   = wy[2];
    word_d.pixel_x3   = wx[3];
    word_d.pixel_y3   = wy[3];
    word_d.pixel_mask = wm;
    word_d.last       = last_pix;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      rem_q       <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_i.data.load_start) begin
        cur_x_q <= in_i.data.start_x;
        cur_y_q <= in_i.data.start_y;
      end else if (advance) begin
        cur_x_q <= x_nxt;
        cur_y_q <= y_nxt;
      end
      if (state_q == StSetup) begin
        slot_q <= '0;
        rem_q  <= s_xmajor ? s_adx : s_ady;
      end else if (advance) begin
        slot_q <= close ? '0 : (slot_q + 1'b1);
        rem_q  <= rem_q - 1'b1;
      end
      if (advance && close) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      end_x_q <= in_i.data.end_x;
      end_y_q <= in_i.data.end_y;
    end
    if (state_q == StSetup) begin
      xneg_q   <= s_xneg;
      yneg_q   <= s_yneg;
      xmajor_q <= s_xmajor;
      major_q  <= s_xmajor ? s_adx : s_ady;
      minor_q  <= s_xmajor ? s_ady : s_adx;
      err_q    <= (s_xmajor ? s_adx : s_ady) >> 1;
    end else if (advance) begin
      err_q <= err_nxt;
    end
    // staging is zero at each word start so unused slots read as zero
    if ((state_q == StSetup) || (advance && close)) begin
      for (int s = 0; s < NumSlots; s++) begin
        stg_x_q[s] <= '0;
        stg_y_q[s] <= '0;
      end
      stg_m_q <= '0;
    end else if (advance) begin
      stg_x_q[slot_q] <= scr_x;
      stg_y_q[slot_q] <= scr_y;
      stg_m_q[slot_q] <= in_clip;
    end
    if (advance && close) begin
      out_data_q <= word_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

// File: tb/sv/bresenham_line_stepper_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top_test: self-checking bench for the line stepper
// Drives line requests and APB register writes into the block. A line
// predictor computes the pixel words each line should produce, and every
// word taken from the output is checked field by field in arrival order.
// ----------------------------------------------------------------------------

module bresenham_line_stepper_top_test;
  import bls_pkg::*;

  localparam int unsigned CycleLimit   = 1_500_000;
  localparam int unsigned SettleCycles = 8;         // covers a zero-length line in flight
  localparam int unsigned MaxGap       = 11;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned NumFields    = 2 * NumSlots + 2;
  localparam int unsigned LongHold     = 400;
  localparam logic [1:0]  UnusedRegIdx = 2'd3;      // no register behind this index

  // one predicted pixel word, tagged for the mismatch report
  typedef struct {
    pix_word_t   word;
    int unsigned line_no;
    int unsigned word_no;
  } pending_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  bls_in_if  line_ch ();
  bls_out_if pix_ch ();

  bresenham_line_stepper_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (line_ch),
    .out_o   (pix_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the kept pen position
  // --------------------------------------------------------------------------
  logic [CoordW-1:0]  pan      = PanRst;
  logic [ScreenW-1:0] clip_w   = ClipWidthRst;
  logic [ScreenW-1:0] clip_h   = ClipHeightRst;
  logic [CoordW-1:0]  pen_x    = '0;
  logic [CoordW-1:0]  pen_y    = '0;

  pending_t pending_words[$];   // words still owed by the block, oldest first

  int unsigned lines_sent   = 0;
  int unsigned empty_lines  = 0;
  int unsigned words_seen   = 0;
  int unsigned pixels_lit   = 0;
  int unsigned settings_run = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // sink side pacing; sink_stall is drawn per word, drain_hold is a long hold-off
  int unsigned sink_stall = 0;
  int unsigned drain_hold = 0;
  bit          idle_on    = 1'b1;   // 0 gives a stretch with no gaps on either side

  string field_name [NumFields] = '{"pixel_x0", "pixel_y0", "pixel_x1", "pixel_y1",
                                    "pixel_x2", "pixel_y2", "pixel_x3", "pixel_y3",
                                    "pixel_mask", "last"};

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  // Rasterize one accepted line and queue the words it must produce.
  // The error term is 8 bits and wraps, so a steep minor axis may fall short
  // of the end point; the pen is left wherever stepping stopped.
  function automatic void raster_line(input line_req_t req);
    logic [CoordW-1:0]  x, y, adx, ady, major, minor, err;
    logic               xneg, yneg, xmajor, minor_step;
    logic [ScreenW-1:0] sx, sy;
    pix_word_t          w;
    int unsigned        n, slot;

    lines_sent++;
    x = req.load_start ? req.start_x : pen_x;
    y = req.load_start ? req.start_y : pen_y;
    pen_x = x;
    pen_y = y;
    if (x == req.end_x && y == req.end_y) begin
      empty_lines++;   // zero-length line: no words, pen rests on the start point
      return;
    end

    xneg   = req.end_x < x;
    yneg   = req.end_y < y;
    adx    = xneg ? x - req.end_x : req.end_x - x;
    ady    = yneg ? y - req.end_y : req.end_y - y;
    xmajor = adx >= ady;
    major  = xmajor ? adx : ady;
    minor  = xmajor ? ady : adx;
    err    = major >> 1;
    w      = '0;

    for (n = 0; n < major; n++) begin
      err        = err + minor;
      minor_step = err >= major;
      if (minor_step) err = err - major;
      if (xmajor || minor_step) x = xneg ? x - 8'd1 : x + 8'd1;
      if (!xmajor || minor_step) y = yneg ? y - 8'd1 : y + 8'd1;

      sx   = ScreenW'(x) + ScreenW'(pan);
      sy   = ScreenW'(y) + ScreenW'(pan);
      slot = n % NumSlots;
      if (slot == 0) w = '0;   // unused trailing slots stay zero
      case (slot)
        0: begin w.pixel_x0 = sx; w.pixel_y0 = sy; end
        1: begin w.pixel_x1 = sx; w.pixel_y1 = sy; end
        2: begin w.pixel_x2 = sx; w.pixel_y2 = sy; end
        default: begin w.pixel_x3 = sx; w.pixel_y3 = sy; end
      endcase
      // clipped pixels keep their coordinates, only the mask bit drops
      if (sx < clip_w && sy < clip_h) w.pixel_mask[slot] = 1'b1;
      if (slot == NumSlots - 1 || n == major - 1) begin
        w.last = (n == major - 1);
        pending_words.push_back('{w, lines_sent, n / NumSlots});
      end
    end
    pen_x = x;
    pen_y = y;
  endfunction

  function automatic logic [ScreenW-1:0] word_field(input pix_word_t w, input int unsigned i);
    case (i)
      0: return w.pixel_x0;
      1: return w.pixel_y0;
      2: return w.pixel_x1;
      3: return w.pixel_y1;
      4: return w.pixel_x2;
      5: return w.pixel_y2;
      6: return w.pixel_x3;
      7: return w.pixel_y3;
      8: return ScreenW'(w.pixel_mask);
      default: return ScreenW'(w.last);
    endcase
  endfunction

  function automatic line_req_t line_of(input logic ld, input logic [CoordW-1:0] sx, sy,
                                        input logic [CoordW-1:0] ex, ey);
    line_req_t r;
    r.load_start = ld;
    r.start_x    = sx;
    r.start_y    = sy;
    r.end_x      = ex;
    r.end_y      = ey;
    return r;
  endfunction

  // Random line: mostly short spans around the start point, some continuing
  // from the pen, a few anywhere on the grid and a few of zero length.
  function automatic line_req_t pick_line(input int unsigned span);
    line_req_t         r;
    logic [CoordW-1:0] bx, by;
    int unsigned       sel;
    r.load_start = ($urandom_range(0, 3) != 0);
    r.start_x    = CoordW'($urandom);
    r.start_y    = CoordW'($urandom);
    bx  = r.load_start ? r.start_x : pen_x;
    by  = r.load_start ? r.start_y : pen_y;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      r.end_x = bx;
      r.end_y = by;
    end else if (sel < 3) begin
      r.end_x = CoordW'($urandom);
      r.end_y = CoordW'($urandom);
    end else begin
      r.end_x = bx + 8'($urandom_range(0, 2 * span) - span);
      r.end_y = by + 8'($urandom_range(0, 2 * span) - span);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Line request driver. valid is left high after a word is taken so that a
  // gap-free follow-up never lowers and raises it in one step; wait_drained
  // drops it when the sender stops.
  // --------------------------------------------------------------------------
  task automatic send_line(input line_req_t req);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      line_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    line_ch.data  = req;
    line_ch.valid = 1'b1;
    @(posedge clk_i);
    while (!line_ch.ready) @(posedge clk_i);
    raster_line(req);
  endtask

  task automatic run_lines(input int unsigned count, input int unsigned span);
    repeat (count) send_line(pick_line(span));
  endtask

  // Stop sending, wait for every owed word, then let a trailing zero-length
  // line finish before anything touches the registers.
  task automatic wait_drained();
    @(negedge clk_i);
    line_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // APB access: setup phase, then access phase until pready
  // --------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                          input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic verify_reg(input reg_idx_e idx);
    logic [DataW-1:0] got, want;
    apb_xfer(1'b0, idx, '0, got);
    case (idx)
      RegPan:       want = DataW'(pan);
      RegClipWidth: want = DataW'(clip_w);
      default:      want = DataW'(clip_h);
    endcase
    if (got !== want) begin
      note_mismatch($sformatf("register %s: expected 0x%0h, got 0x%0h",
                              idx.name(), want, got));
    end
  endtask

  // Write a register with junk above its width, track it, and read it back (the unmapped index is not read back).
  task automatic program_reg(input logic [1:0] idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] field_mask, wdata, unused_rd;
    case (idx)
      RegPan:                      field_mask = DataW'(8'hFF);
      RegClipWidth, RegClipHeight: field_mask = DataW'(9'h1FF);
      default:                     field_mask = '1;
    endcase
    wdata = (val & field_mask) | ($urandom & ~field_mask);
    apb_xfer(1'b1, idx, wdata, unused_rd);
    case (idx)
      RegPan:        pan    = wdata[CoordW-1:0];
      RegClipWidth:  clip_w = wdata[ScreenW-1:0];
      RegClipHeight: clip_h = wdata[ScreenW-1:0];
      default: ;   // unmapped index, block ignores it
    endcase
    if (idx != UnusedRegIdx) verify_reg(reg_idx_e'(idx));
  endtask

  task automatic apply_view(input int unsigned off, input int unsigned wd, input int unsigned ht);
    wait_drained();
    program_reg(RegPan, off);
    program_reg(RegClipWidth, wd);
    program_reg(RegClipHeight, ht);
    settings_run++;
  endtask

  // --------------------------------------------------------------------------
  // Pixel word sink and checker
  // --------------------------------------------------------------------------
  initial begin : pixel_sink
    pix_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (drain_hold != 0) begin
        pix_ch.ready = 1'b0;
        drain_hold--;
      end else if (sink_stall != 0) begin
        pix_ch.ready = 1'b0;
        sink_stall--;
      end else begin
        pix_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    pending_t due;
    if (rst_ni && pix_ch.valid && pix_ch.ready) begin
      words_seen++;
      sink_stall = idle_on ? $urandom_range(0, MaxGap) : 0;
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("pixel word with no line owing it: %p", pix_ch.data));
      end else begin
        due = pending_words.pop_front();
        pixels_lit += $countones(due.word.pixel_mask);
        for (int unsigned i = 0; i < NumFields; i++) begin
          if (word_field(pix_ch.data, i) !== word_field(due.word, i)) begin
            note_mismatch($sformatf("line %0d word %0d %s: expected 0x%0h, got 0x%0h",
                                    due.line_no, due.word_no, field_name[i],
                                    word_field(due.word, i), word_field(pix_ch.data, i)));
          end
        end
      end
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles with %0d words outstanding",
             cycle_cnt, pending_words.size());
    $display("bresenham_line_stepper_top_test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_defaults();
    verify_reg(RegPan);
    verify_reg(RegClipWidth);
    verify_reg(RegClipHeight);
  endtask

  // Default view: offset 16, clip 320 x 160, so y >= 144 is clipped.
  task automatic test_directed_lines();
    send_line(line_of(1'b0, 8'h00, 8'h00, 8'd0,   8'd0));    // zero length at reset pen
    send_line(line_of(1'b0, 8'hFF, 8'hFF, 8'd5,   8'd0));    // kept pen, start ignored
    send_line(line_of(1'b0, 8'hA5, 8'h5A, 8'd7,   8'd9));    // steep, continues
    send_line(line_of(1'b1, 8'd255, 8'd255, 8'd0, 8'd0));    // full diagonal, up-left
    send_line(line_of(1'b1, 8'd0,   8'd0, 8'd255, 8'd0));    // full horizontal
    send_line(line_of(1'b0, 8'd0,   8'd0, 8'd255, 8'd255));  // full vertical from pen
    send_line(line_of(1'b1, 8'd0, 8'd255, 8'd255, 8'd0));    // full anti-diagonal
    send_line(line_of(1'b1, 8'd0,   8'd0, 8'd255, 8'd254));  // error term wraps, x major
    send_line(line_of(1'b1, 8'd255, 8'd0, 8'd1,   8'd255));  // error term wraps, y major
    send_line(line_of(1'b1, 8'd10, 8'd10, 8'd11,  8'd10));   // single pixel
    send_line(line_of(1'b1, 8'd10, 8'd10, 8'd9,   8'd13));   // steep, left
    send_line(line_of(1'b1, 8'd100, 8'd100, 8'd97, 8'd99));  // shallow, up-left
    send_line(line_of(1'b1, 8'd100, 8'd100, 8'd104, 8'd100)); // exactly one full word
    send_line(line_of(1'b1, 8'd200, 8'd200, 8'd200, 8'd200)); // zero length, loaded
    send_line(line_of(1'b0, 8'd0,   8'd0, 8'd200, 8'd195));  // short, up from pen
    send_line(line_of(1'b1, 8'd128, 8'd127, 8'd127, 8'd128)); // one diagonal step
    send_line(line_of(1'b1, 8'd3, 8'd140, 8'd20,  8'd150));  // crosses the clip row
    send_line(line_of(1'b1, 8'd40,  8'd0, 8'd40,  8'd3));    // partial last word
    send_line(line_of(1'b1, 8'd255, 8'd128, 8'd250, 8'd255)); // steep, down-left
    send_line(line_of(1'b1, 8'd0, 8'd128, 8'd255, 8'd129));  // long, nearly flat
  endtask

  // Register extremes, including wrap-free max offset and fully closed clip.
  task automatic test_config_sweep();
    apply_view(0, 511, 511);
    run_lines(10, 16);
    apply_view(255, 0, 0);
    run_lines(10, 16);
    apply_view(255, 300, 250);
    run_lines(10, 24);
    apply_view(0, 1, 1);
    run_lines(10, 8);
    apply_view(200, 511, 0);
    run_lines(10, 16);
    apply_view($urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 511));
    run_lines(10, 32);
    // write to the unmapped index must leave all three registers alone
    wait_drained();
    program_reg(UnusedRegIdx, $urandom);
    test_register_defaults();
    run_lines(10, 16);
    apply_view(PanRst, ClipWidthRst, ClipHeightRst);
    run_lines(10, 16);
  endtask

  // Sink holds off long enough for the output register to fill and the
  // line input to stall; then the sender waits for a full drain.
  task automatic test_output_backpressure();
    wait_drained();
    drain_hold = LongHold;
    run_lines(12, 40);
    wait_drained();
    run_lines(8, 12);
  endtask

  task automatic test_random_lines();
    for (int unsigned s = 0; s < 4; s++) begin
      idle_on = (s != 1);
      run_lines(50, (s == 3) ? 60 : 12);
      if (s == 2) wait_drained();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    line_ch.valid = 1'b0;
    line_ch.data  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_defaults();
    test_directed_lines();
    test_config_sweep();
    test_output_backpressure();
    test_random_lines();
    wait_drained();

    $display("Ran %0d lines (%0d zero length): %0d pixel words, %0d pixels inside clip",
             lines_sent, empty_lines, words_seen, pixels_lit);
    $display("Used %0d register settings and one long output stall in %0d cycles",
             settings_run + 1, cycle_cnt);
    if (mismatch_cnt == 0 && pending_words.size() == 0) begin
      $display("bresenham_line_stepper_top_test passed");
    end else begin
      $display("bresenham_line_stepper_top_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/bls_pkg.sv
src/bls_in_if.sv
src/bls_out_if.sv
src/bresenham_line_stepper_top.sv
tb/sv/bresenham_line_stepper_top_test.sv
